// ----- design/switch_debounce_fsm_core_macros.svh -----
// Assertion macros shared by the switch debouncer RTL.
`ifndef SWITCH_DEBOUNCE_FSM_CORE_MACROS_SVH
`define SWITCH_DEBOUNCE_FSM_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside reset.
`define SDFSM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("debouncer assertion failed");

// Checks that a condition never holds outside reset.
`define SDFSM_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("debouncer forbidden condition seen");

`else

`define SDFSM_ASSERT(label, clk, rst_n, prop)
`define SDFSM_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- design/sdfsm_pkg.sv -----
// Shared constants and types of the switch debouncer.
`default_nettype none

package sdfsm_pkg;

  localparam int unsigned NumSwitches = 2;
  localparam int unsigned HistW       = 5;
  localparam int unsigned StateW      = 2;
  localparam int unsigned TickW       = 8;
  localparam int unsigned PeriodW     = 10;
  localparam int unsigned ElapsedW    = PeriodW;
  localparam int unsigned SumW        = PeriodW + 1;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 10;
  localparam int unsigned StatesW     = StateW * NumSwitches;

  localparam logic [TickW-1:0]   TickReset   = TickW'(5);
  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(20);

  typedef logic [NumSwitches-1:0] levels_t;
  typedef logic [StatesW-1:0]     states_t;
  typedef logic [CfgDataW-1:0]    cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegTickMs   = 2'd0,
    RegPeriodMs = 2'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- design/sdfsm_intf.sv -----
// Handshake channel interfaces of the switch debouncer.
`default_nettype none

interface sdfsm_in_if;
  import sdfsm_pkg::*;
  logic    valid;
  logic    ready;
  levels_t levels;
  modport source (output valid, output levels, input ready);
  modport sink (input valid, input levels, output ready);
endinterface

interface sdfsm_out_if;
  import sdfsm_pkg::*;
  logic    valid;
  logic    ready;
  states_t switch_states;
  logic    sampled;
  modport source (output valid, output switch_states, output sampled, input ready);
  modport sink (input valid, input switch_states, input sampled, output ready);
endinterface

interface sdfsm_cfg_if;
  import sdfsm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CfgIdxW-1:0]         index;
  cfg_data_t                  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/switch_debounce_fsm_core.sv -----
// Top level of the switch debouncer: tick accumulator, sample histories and state machines.
`default_nettype none
`include "switch_debounce_fsm_core_macros.svh"

// Each input word is one timer tick carrying the raw active-low levels of all switches.
// The tick adds tick_ms to a millisecond accumulator; when the sum reaches period_ms the
// accumulator clears, every switch shifts its level into a five-sample history and steps
// its four-state machine (released, pre-pressed, pressed, pre-released). Every tick
// returns one word with all switch states and a flag telling whether it sampled. The
// whole update is one level of logic from the state registers to the output register,
// so a tick is taken in every cycle and its word appears in the next cycle; the input
// stalls only while the output register holds a word that is not being taken.
// Configuration writes are always accepted and must only happen while the block is idle.
module switch_debounce_fsm_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sdfsm_in_if.sink   in_i,
  sdfsm_out_if.source out_o,
  sdfsm_cfg_if.sink  cfg_i
);
  import sdfsm_pkg::*;

  typedef enum logic [StateW-1:0] {
    StReleased    = 2'd0,
    StPrePressed  = 2'd1,
    StPressed     = 2'd2,
    StPreReleased = 2'd3
  } dstate_e;

  localparam logic [HistW-1:0] EdgeMask  = 5'b11011;
  localparam logic [HistW-1:0] StableMask = 5'b11100;
  localparam logic [HistW-1:0] PressEdge = 5'b00011;
  localparam logic [HistW-1:0] RelEdge   = 5'b11000;
  localparam logic [HistW-1:0] PressHeld = 5'b00000;
  localparam logic [HistW-1:0] RelHeld   = 5'b11100;

  logic [TickW-1:0]    tick_q;
  logic [PeriodW-1:0]  period_q;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [SumW-1:0]     sum;
  logic                fire;
  logic                in_acc;
  logic                out_valid_q;
  states_t             states_q;
  logic                sampled_q;

  logic    [HistW-1:0] hist_q  [NumSwitches];
  logic    [HistW-1:0] hist_d  [NumSwitches];
  dstate_e             state_q [NumSwitches];
  dstate_e             state_d [NumSwitches];
  states_t             states_d;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign sum       = {1'b0, elapsed_q} + SumW'(tick_q);
  assign fire      = sum >= {1'b0, period_q};
  assign elapsed_d = fire ? '0 : sum[ElapsedW-1:0];

  always_comb begin
    states_d = '0;
    for (int i = 0; i < NumSwitches; i++) begin
      hist_d[i]  = fire ? {in_i.levels[i], hist_q[i][HistW-1:1]} : hist_q[i];
      state_d[i] = state_q[i];
      if (fire) begin
        unique case (state_q[i])
          StReleased: begin
            if ((hist_d[i] & EdgeMask) == PressEdge) state_d[i] = StPrePressed;
          end
          StPrePressed: begin
            if ((hist_d[i] & StableMask) == PressHeld) state_d[i] = StPressed;
          end
          StPressed: begin
            if ((hist_d[i] & EdgeMask) == RelEdge) state_d[i] = StPreReleased;
          end
          StPreReleased: begin
            if ((hist_d[i] & StableMask) == RelHeld) state_d[i] = StReleased;
          end
          default: begin
            state_d[i] = state_q[i];
          end
        endcase
      end
      states_d[StateW*i +: StateW] = state_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= TickReset;
      period_q <= PeriodReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegTickMs:   tick_q   <= cfg_i.data[TickW-1:0];
        RegPeriodMs: period_q <= cfg_i.data[PeriodW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      for (int i = 0; i < NumSwitches; i++) begin
        hist_q[i]  <= '1;
        state_q[i] <= StReleased;
      end
    end else if (in_acc) begin
      elapsed_q <= elapsed_d;
      for (int i = 0; i < NumSwitches; i++) begin
        hist_q[i]  <= hist_d[i];
        state_q[i] <= state_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      states_q  <= '0;
      sampled_q <= 1'b0;
    end else if (in_acc) begin
      states_q  <= states_d;
      sampled_q <= fire;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.switch_states = states_q;
  assign out_o.sampled       = sampled_q;

  `SDFSM_ASSERT(a_sampled_flag, clk_i, rst_ni, in_acc |=> out_o.valid && (out_o.sampled == $past(fire)))
  `SDFSM_ASSERT(a_hold_unsampled, clk_i, rst_ni, (in_acc && !fire) |=> $stable(states_q) || ($past(states_q) == states_q))
  `SDFSM_ASSERT(a_elapsed_clear, clk_i, rst_ni, (in_acc && fire) |=> elapsed_q == '0)
  `SDFSM_ASSERT_NEVER(a_elapsed_bound, clk_i, rst_ni, in_acc && !fire && (elapsed_d >= period_q))

endmodule

`default_nettype wire

// ----- test/sdfsm_checker.sv -----
// Checker of the switch debouncer: watches all channels, predicts each result word and compares.
`timescale 1ns / 100ps

module sdfsm_checker
  import sdfsm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sdfsm_in_if         in_w,
  sdfsm_out_if        out_w,
  sdfsm_cfg_if        cfg_w,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [StateW-1:0] {
    SwReleased    = 2'd0,
    SwPrePressed  = 2'd1,
    SwPressed     = 2'd2,
    SwPreReleased = 2'd3
  } dbc_state_e;

  typedef struct packed {
    states_t switch_states;
    logic    sampled;
  } tick_result_t;

  tick_result_t       expected_q[$];
  tick_result_t       want;
  logic [TickW-1:0]   tick_ms;
  logic [PeriodW-1:0] period_ms;
  logic [SumW-1:0]    elapsed_ms;
  logic [HistW-1:0]   history [NumSwitches];
  dbc_state_e         dbc_state [NumSwitches];

  function automatic dbc_state_e next_dbc_state(dbc_state_e st, logic [HistW-1:0] h);
    case (st)
      SwReleased: begin
        return (h[4:3] == 2'b00 && h[1:0] == 2'b11) ? SwPrePressed : SwReleased;
      end
      SwPrePressed: begin
        return (h[4:2] == 3'b000) ? SwPressed : SwPrePressed;
      end
      SwPressed: begin
        return (h[4:3] == 2'b11 && h[1:0] == 2'b00) ? SwPreReleased : SwPressed;
      end
      default: begin
        return (h[4:2] == 3'b111) ? SwReleased : SwPreReleased;
      end
    endcase
  endfunction

  // Overshoot past the period is dropped when the accumulator clears.
  function automatic tick_result_t predict_tick(levels_t lv);
    tick_result_t res;
    logic         fire;
    elapsed_ms = elapsed_ms + SumW'(tick_ms);
    fire = (elapsed_ms >= SumW'(period_ms));
    if (fire) begin
      elapsed_ms = '0;
      for (int i = 0; i < NumSwitches; i++) begin
        history[i] = {lv[i], history[i][HistW-1:1]};
        dbc_state[i] = next_dbc_state(dbc_state[i], history[i]);
      end
    end
    for (int i = 0; i < NumSwitches; i++) begin
      res.switch_states[StateW*i +: StateW] = dbc_state[i];
    end
    res.sampled = fire;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    fail_count_o++;
    if (fail_count_o <= 50) begin
      $display("sdfsm_checker: %s mismatch at %0t: got %0h, wanted %0h",
               what, $realtime, got, exp_val);
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms = TickReset;
      period_ms = PeriodReset;
      elapsed_ms = '0;
      for (int i = 0; i < NumSwitches; i++) begin
        history[i] = '1;
        dbc_state[i] = SwReleased;
      end
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_w.valid === 1'b1 && cfg_w.ready === 1'b1) begin
        case (cfg_w.index)
          RegTickMs: begin
            tick_ms = cfg_w.data[TickW-1:0];
          end
          RegPeriodMs: begin
            period_ms = cfg_w.data[PeriodW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_w.valid === 1'b1 && out_w.ready === 1'b1) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 32'(out_w.switch_states), 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (out_w.switch_states !== want.switch_states) begin
            report_mismatch("switch_states", 32'(out_w.switch_states),
                            32'(want.switch_states));
          end
          if (out_w.sampled !== want.sampled) begin
            report_mismatch("sampled", 32'(out_w.sampled), 32'(want.sampled));
          end
        end
      end
      if (in_w.valid === 1'b1 && in_w.ready === 1'b1) begin
        expected_q.push_back(predict_tick(in_w.levels));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
// Testbench top of the switch debouncer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import sdfsm_pkg::*;

  typedef enum int unsigned {
    RxAlways,
    RxHalf,
    RxSparse
  } rx_mode_e;

  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;
  localparam int unsigned HoldCycles = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fails;
  int unsigned pending;

  int unsigned hold_reqs = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  rx_mode_e    rx_mode = RxAlways;
  int unsigned mode_left = 0;

  levels_t     run_level = '1;
  int          run_left [NumSwitches];
  int          tps = 1;

  levels_t press_walk [14] = '{2'b10, 2'b10, 2'b10, 2'b01, 2'b01, 2'b11, 2'b01,
                               2'b01, 2'b00, 2'b00, 2'b11, 2'b11, 2'b11, 2'b10};

  sdfsm_in_if  tick_ch ();
  sdfsm_out_if state_ch ();
  sdfsm_cfg_if cfg_ch ();

  switch_debounce_fsm_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_ch),
    .out_o  (state_ch),
    .cfg_i  (cfg_ch)
  );

  sdfsm_checker watch (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_w         (tick_ch),
    .out_w        (state_ch),
    .cfg_w        (cfg_ch),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      hold_left <= HoldCycles;
      state_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      state_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 2));
        mode_left <= $urandom_range(8, 64);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RxAlways: begin
          state_ch.ready <= 1'b1;
        end
        RxHalf: begin
          state_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          state_ch.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Levels mostly hold for whole runs of samples so the state machines advance.
  function automatic levels_t shaped_levels();
    levels_t lv;
    for (int i = 0; i < NumSwitches; i++) begin
      if (run_left[i] <= 0) begin
        run_level[i] = ~run_level[i];
        run_left[i] = $urandom_range(1, 8) * tps;
      end
      run_left[i]--;
      lv[i] = run_level[i];
      if ($urandom_range(0, 15) == 0) begin
        lv[i] = ~lv[i];
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      lv = levels_t'($urandom);
    end
    return lv;
  endfunction

  task automatic send_tick(levels_t lv);
    @(negedge clk);
    tick_ch.valid <= 1'b1;
    tick_ch.levels <= lv;
    do @(posedge clk); while (tick_ch.ready !== 1'b1);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, cfg_data_t value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned items);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 16);
      for (int unsigned k = 0; k < burst && sent < items; k++) begin
        send_tick(shaped_levels());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        tick_ch.valid <= 1'b0;
      end
    end
  endtask

  task automatic phase(cfg_data_t tick_word, cfg_data_t period_word, int unsigned items,
                       bit with_hold);
    int unsigned t;
    int unsigned p;
    settle();
    write_reg(RegTickMs, tick_word);
    write_reg(RegPeriodMs, period_word);
    t = tick_word[TickW-1:0];
    p = period_word[PeriodW-1:0];
    tps = (t == 0 || p == 0) ? 1 : (p + t - 1) / t;
    if (tps > 16) begin
      tps = 16;
    end
    for (int i = 0; i < NumSwitches; i++) begin
      if (run_left[i] > 8 * tps) begin
        run_left[i] = 8 * tps;
      end
    end
    if (with_hold) begin
      hold_reqs <= hold_reqs + 1;
      repeat (24) send_tick(shaped_levels());
    end
    run_phase(items);
  endtask

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int unsigned tick_v;
    int unsigned period_v;
    int unsigned waited;
    tick_ch.valid = 1'b0;
    tick_ch.levels = '0;
    state_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int i = 0; i < NumSwitches; i++) begin
      run_left[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_tick(2'b00);
    send_tick(2'b11);
    send_tick(2'b01);
    send_tick(2'b10);
    settle();
    write_reg(RegTickMs, cfg_data_t'(1));
    write_reg(RegPeriodMs, cfg_data_t'(1));
    foreach (press_walk[k]) begin
      send_tick(press_walk[k]);
    end

    phase(cfg_data_t'(255), cfg_data_t'(1000), 60, 1'b0);
    phase(cfg_data_t'(0), cfg_data_t'(0), 40, 1'b0);
    phase(cfg_data_t'(0), cfg_data_t'(5), 20, 1'b0);
    phase(10'h301, 10'h3FF, 40, 1'b0);
    phase(cfg_data_t'(3), cfg_data_t'(3), 40, 1'b0);
    settle();
    write_reg(RegSpareA, 10'h3FF);
    write_reg(RegSpareB, 10'h155);
    run_phase(30);
    phase(cfg_data_t'(7), cfg_data_t'(20), 60, 1'b0);
    phase(cfg_data_t'(255), cfg_data_t'(1), 40, 1'b0);

    for (int r = 0; r < 6; r++) begin
      tick_v = $urandom_range(1, 255);
      if ($urandom_range(0, 3) == 0 || tick_v * 4 > 1000) begin
        period_v = $urandom_range(1, 1000);
      end else begin
        period_v = $urandom_range(1, tick_v * 4);
      end
      phase(cfg_data_t'(tick_v), cfg_data_t'(period_v), 80, (r == 0 || r == 3));
    end

    @(negedge clk);
    tick_ch.valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (5) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
